// ----- rtl/sgm_pkg.sv -----
// shared constants and types of the sobel gradient magnitude block
package sgm_pkg;

	localparam int MaxWidth    = 4096;
	localparam int PixelBits   = 8;
	localparam int DimBits     = 13;
	localparam int DimCap      = 4096;
	localparam int DimMin      = 3;
	localparam int WidthCap    = (MaxWidth < DimCap) ? MaxWidth : DimCap;
	localparam int AddrBits    = $clog2(WidthCap);
	localparam int CoordBits   = 12;
	localparam int MagBits     = 8;
	localparam int GradBits    = PixelBits + 3;
	localparam int QuotBits    = GradBits - 2;
	localparam int SumBits     = 2 * QuotBits;
	localparam int RootBits    = SumBits / 2;
	localparam int RemBits     = RootBits + 3;
	localparam int StepBits    = $clog2(RootBits);
	localparam int QueueDepth  = 4;
	localparam int QueuePtrBits = $clog2(QueueDepth);
	localparam int CfgIdxBits  = 1;
	localparam int ResetWidth  = 640;
	localparam int ResetHeight = 480;

	typedef logic [PixelBits-1:0] pix_t;

	// configuration register indexes
	typedef enum logic [CfgIdxBits-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// one full window handed from the front to the back
	typedef struct packed {
		pix_t [8:0]           win;
		logic [CoordBits-1:0] col;
		logic [CoordBits-1:0] row;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_ROOT,
		BK_OUT
	} back_state_t;

endpackage

// ----- rtl/sobel_gradient_magnitude.sv -----
// top level of the sobel gradient magnitude block
//
//  channel   direction  signals                      contents (low bit up)
//  s_*       in         s_tvalid s_tready s_tdata    tdata: pixel[7:0]; tuser: frame_start
//  m_*       out        m_tvalid m_tready m_tdata    magnitude[7:0] center_col[19:8]
//                                                    center_row[31:20]
//  cfg_*     in         cfg_we cfg_index cfg_data    0 image_width, 1 image_height
//
// The front end takes one pixel per cycle unless the queue is full; line buffer read on accept,
// written as it leaves stage 1. Back end per interior pixel: load, square, nine root steps, output.
// Up to four windows wait in the queue; the front stalls only when the queue is full.
// Reset clears counters, window and control; the line buffers need no clearing pass.
// A register write restarts the frame at column 0, row 0.
module sobel_gradient_magnitude (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // pixel
	input  logic                           s_tuser,   // frame_start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // magnitude, center_col, center_row
	input  logic                           cfg_we,
	input  logic [sgm_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [sgm_pkg::DimBits-1:0]    cfg_data
);
	import sgm_pkg::*;

	logic [DimBits-1:0] width_q, height_q, width_eff, height_eff;
	logic               job_valid, job_ready, head_valid, head_pop;
	job_t               job, head;
	logic [MagBits-1:0]   res_mag;
	logic [CoordBits-1:0] res_col, res_row;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimBits'(ResetWidth);
			height_q <= DimBits'(ResetHeight);
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// dimensions held to their legal ranges
	always_comb begin
		width_eff = width_q;
		if (width_q < DimBits'(DimMin)) width_eff = DimBits'(DimMin);
		if (width_q > DimBits'(WidthCap)) width_eff = DimBits'(WidthCap);
		height_eff = height_q;
		if (height_q < DimBits'(DimMin)) height_eff = DimBits'(DimMin);
		if (height_q > DimBits'(DimCap)) height_eff = DimBits'(DimCap);
	end

	sgm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.cnt_clear  (cfg_we),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_pixel   (s_tdata),
		.in_start   (s_tuser),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	sgm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_job   (job),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_job    (head)
	);

	sgm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (head_valid),
		.job_pop    (head_pop),
		.job        (head),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_mag    (res_mag),
		.res_col    (res_col),
		.res_row    (res_row)
	);

	assign m_tdata = {res_row, res_col, res_mag};

endmodule

// ----- rtl/sgm_front.sv -----
// front end: raster counters, two line buffers and the 3x3 window
module sgm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sgm_pkg::DimBits-1:0]  width_eff,
	input  logic [sgm_pkg::DimBits-1:0]  height_eff,
	input  logic                         cnt_clear,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sgm_pkg::pix_t                in_pixel,
	input  logic                         in_start,
	output logic                         job_valid,
	input  logic                         job_ready,
	output sgm_pkg::job_t                job
);
	import sgm_pkg::*;

	logic [CoordBits-1:0] col_q, row_q;
	logic [CoordBits-1:0] col_base, row_base, col_cur, row_cur;
	logic [CoordBits-1:0] col_nxt, row_nxt;
	logic                 col_last, row_last, acc;

	logic                 s1_valid;
	pix_t                 px_s1, rd1_s1, rd2_s1;
	logic [CoordBits-1:0] col_s1, row_s1;
	logic                 hit_s1;
	logic                 s1_emit, s1_fire;
	pix_t                 up1, up2;
	pix_t                 last_px_q, last_up1_q;
	pix_t [8:0]           win_q, win_next;

	pix_t line1 [WidthCap];
	pix_t line2 [WidthCap];

	assign acc = in_valid && in_ready;

	// position of the incoming pixel
	always_comb begin
		col_base = in_start ? '0 : col_q;
		row_base = in_start ? '0 : row_q;
		col_cur  = ({1'b0, col_base} >= width_eff)  ? '0 : col_base;
		row_cur  = ({1'b0, row_base} >= height_eff) ? '0 : row_base;
		col_last = (DimBits'(col_cur) + DimBits'(1)) >= width_eff;
		row_last = (DimBits'(row_cur) + DimBits'(1)) >= height_eff;
		col_nxt  = col_last ? '0 : col_cur + CoordBits'(1);
		if (col_last) begin
			row_nxt = row_last ? '0 : row_cur + CoordBits'(1);
		end else begin
			row_nxt = row_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cnt_clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// stage 1 handshake
	assign s1_emit  = s1_valid && (row_s1 >= CoordBits'(2)) && (col_s1 >= CoordBits'(2));
	assign s1_fire  = s1_valid && (!s1_emit || job_ready);
	assign in_ready = !s1_valid || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (acc) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1  <= in_pixel;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
			// same column written back on this edge: take the forwarded bytes
			hit_s1 <= s1_fire && (col_s1 == col_cur);
		end
	end

	// line buffers, read on accept and written when stage 1 retires
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			line1[col_s1[AddrBits-1:0]] <= px_s1;
			line2[col_s1[AddrBits-1:0]] <= up1;
		end
		if (acc) begin
			rd1_s1 <= line1[col_cur[AddrBits-1:0]];
			rd2_s1 <= line2[col_cur[AddrBits-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			last_px_q  <= px_s1;
			last_up1_q <= up1;
		end
	end

	assign up1 = hit_s1 ? last_px_q  : rd1_s1;
	assign up2 = hit_s1 ? last_up1_q : rd2_s1;

	// window shift, new column on the right
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[3*k]     = win_q[3*k+1];
			win_next[3*k + 1] = win_q[3*k+2];
		end
		win_next[2] = up2;
		win_next[5] = up1;
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_fire) begin
			win_q <= win_next;
		end
	end

	assign job_valid = s1_emit;
	assign job.win   = win_next;
	assign job.col   = col_s1 - CoordBits'(1);
	assign job.row   = row_s1 - CoordBits'(1);

endmodule

// ----- rtl/sgm_queue.sv -----
// short window queue between front and back
module sgm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  sgm_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output sgm_pkg::job_t pop_job
);
	import sgm_pkg::*;

	job_t                    slot_q [QueueDepth];
	logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [QueuePtrBits:0]   count_q;
	logic                    do_push, do_pop;

	assign push_ready = (count_q != (QueuePtrBits+1)'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrBits'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrBits'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QueuePtrBits+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QueuePtrBits+1)'(1);
			end
		end
	end

endmodule

// ----- rtl/sgm_back.sv -----
// back end: sobel sums, squares and a bit-serial square root
module sgm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_pop,
	input  sgm_pkg::job_t                 job,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [sgm_pkg::MagBits-1:0]   res_mag,
	output logic [sgm_pkg::CoordBits-1:0] res_col,
	output logic [sgm_pkg::CoordBits-1:0] res_row
);
	import sgm_pkg::*;

	back_state_t state_q, state_d;

	logic signed [GradBits-1:0] p [9];
	logic signed [GradBits-1:0] gx, gy, gx_b, gy_b;
	logic signed [QuotBits-1:0] qx_q, qy_q;
	logic signed [2*QuotBits-1:0] sq_x, sq_y;
	logic [SumBits-1:0]   rad_q;
	logic [RemBits-1:0]   rem_q, rem_sh, trial;
	logic [RootBits-1:0]  root_q;
	logic [StepBits-1:0]  step_q;
	logic [CoordBits-1:0] col_q, row_q;
	logic                 load_en, square_en, root_en;

	// gradient sums, divided by four toward zero
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			p[k] = $signed({3'b000, job.win[k]});
		end
		gx = (p[0] - p[2]) + ((p[3] - p[5]) <<< 1) + (p[6] - p[8]);
		gy = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
		gx_b = gx + (gx[GradBits-1] ? GradBits'(3) : GradBits'(0));
		gy_b = gy + (gy[GradBits-1] ? GradBits'(3) : GradBits'(0));
	end

	assign sq_x = qx_q * qx_q;
	assign sq_y = qy_q * qy_q;

	// one root bit per step
	assign rem_sh = {rem_q[RemBits-3:0], rad_q[SumBits-1 -: 2]};
	assign trial  = RemBits'({root_q, 2'b01});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:   if (job_valid) state_d = BK_SQUARE;
			BK_SQUARE: state_d = BK_ROOT;
			BK_ROOT:   if (step_q == '0) state_d = BK_OUT;
			BK_OUT:    if (res_ready) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		job_pop   = 1'b0;
		res_valid = 1'b0;
		load_en   = 1'b0;
		square_en = 1'b0;
		root_en   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_pop = job_valid;
				load_en = job_valid;
			end
			BK_SQUARE: square_en = 1'b1;
			BK_ROOT:   root_en   = 1'b1;
			BK_OUT:    res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load_en) begin
			qx_q  <= gx_b[GradBits-1:2];
			qy_q  <= gy_b[GradBits-1:2];
			col_q <= job.col;
			row_q <= job.row;
		end
		if (square_en) begin
			rad_q  <= SumBits'({1'b0, sq_x[SumBits-2:0]}) + SumBits'({1'b0, sq_y[SumBits-2:0]});
			rem_q  <= '0;
			root_q <= '0;
			step_q <= StepBits'(RootBits - 1);
		end
		if (root_en) begin
			rad_q  <= {rad_q[SumBits-3:0], 2'b00};
			step_q <= step_q - StepBits'(1);
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RootBits-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RootBits-2:0], 1'b0};
			end
		end
	end

	assign res_mag = root_q[MagBits-1:0];
	assign res_col = col_q;
	assign res_row = row_q;

endmodule
